// ===== hw/rtl/bspc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bspc_pkg
// Shared types and codes for the bounded stack with palindrome check.
// ---------------------------------------------------------------------------
package bspc_pkg;

  localparam int WORD_W        = 32;
  localparam int DEPTH_W       = 4;
  localparam int DEF_STACK_DEPTH = 8;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [WORD_W-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic                     is_palindrome;
    logic [DEPTH_W-1:0]       depth_now;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_CHK
  } state_t;

endpackage : bspc_pkg
`default_nettype wire

// ===== hw/rtl/bspc_mem.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bspc_mem
// Stack storage: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module bspc_mem #(
  parameter int DEPTH = bspc_pkg::DEF_STACK_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [bspc_pkg::WORD_W-1:0]    wr_data,
  input  wire logic [AW-1:0]                  rd_addr_a,
  input  wire logic [AW-1:0]                  rd_addr_b,
  output      logic [bspc_pkg::WORD_W-1:0]    rd_data_a,
  output      logic [bspc_pkg::WORD_W-1:0]    rd_data_b
);
  import bspc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule : bspc_mem
`default_nettype wire

// ===== hw/rtl/bounded_stack_palindrome_check_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_stack_palindrome_check_core
// Bounded LIFO of signed words with overflow/underflow status and a
// palindrome check of the stored contents.
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off. Push,
// a refused pop, an unused command and a check of zero or one entries are
// answered from ST_IDLE: the result shows the next cycle and busy stays low.
// A pop passes through ST_POP, where the registered read data of the stack
// memory is captured. A check of n entries (n >= 2) walks inward in ST_CHK: the
// memory's two read ports fetch one bottom/top pair per cycle and the pair is
// compared the cycle after; a mismatch ends the walk early.
module bounded_stack_palindrome_check_core #(
  parameter int STACK_DEPTH = bspc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire bspc_pkg::request_t request,
  output      logic               done,
  output      bspc_pkg::result_t  result
);
  import bspc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] hi, hi_next;
  logic          last, last_next;
  logic          done_next;
  result_t       result_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [WORD_W-1:0] rd_data_a;
  logic [WORD_W-1:0] rd_data_b;

  bspc_mem #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (request.push_value),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    lo     <= lo_next;
    hi     <= hi_next;
    last   <= last_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    lo_next     = lo;
    hi_next     = hi;
    last_next   = last;
    done_next   = 1'b0;
    result_next = result;
    wr_en       = 1'b0;
    wr_addr     = AW'(count);
    rd_addr_a   = lo;
    rd_addr_b   = hi;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          result_next.pop_value     = '0;
          result_next.status        = STAT_OK;
          result_next.is_palindrome = 1'b0;
          unique case (request.cmd)
            CMD_PUSH: begin
              done_next = 1'b1;
              if (count == CW'(STACK_DEPTH)) begin
                result_next.status = STAT_OVERFLOW;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                done_next          = 1'b1;
                result_next.status = STAT_UNDERFLOW;
              end else begin
                rd_addr_a  = AW'(count - 1'b1);
                count_next = count - 1'b1;
                state_next = ST_POP;
              end
            end
            CMD_CHECK: begin
              if ({1'b0, count} <= (CW+1)'(1)) begin
                done_next                 = 1'b1;
                result_next.is_palindrome = 1'b1;
              end else begin
                // fetch the outermost pair, queue the next one inward
                rd_addr_a  = '0;
                rd_addr_b  = AW'(count - 1'b1);
                lo_next    = AW'(1);
                hi_next    = AW'(count - CW'(2));
                last_next  = ({2'b0, count} <= (CW+2)'(3));
                state_next = ST_CHK;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        done_next             = 1'b1;
        result_next.pop_value = rd_data_a;
        state_next            = ST_IDLE;
      end
      ST_CHK: begin
        // compare the pair read last cycle, fetch the next one meanwhile
        lo_next   = lo + 1'b1;
        hi_next   = hi - 1'b1;
        last_next = (({1'b0, hi} - {1'b0, lo}) <= (AW+1)'(2));
        if (rd_data_a != rd_data_b) begin
          done_next                 = 1'b1;
          result_next.is_palindrome = 1'b0;
          state_next                = ST_IDLE;
        end else if (last) begin
          done_next                 = 1'b1;
          result_next.is_palindrome = 1'b1;
          state_next                = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (done_next) begin
      result_next.depth_now = DEPTH_W'({{DEPTH_W{1'b0}}, count_next});
    end
  end

`ifndef SYNTHESIS
  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.cmd == CMD_PUSH) |=> (done && !busy))
    else $error("push did not complete in one cycle");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_OVERFLOW) |-> (count == CW'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_UNDERFLOW) |->
      (count == '0 && result.pop_value == '0))
    else $error("underflow reported on a non-empty stack");

  a_check_no_pop: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_palindrome) |->
      (result.status == STAT_OK && result.pop_value == '0))
    else $error("check result carries pop data or an error status");

  a_pop_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (done && state == ST_IDLE))
    else $error("pop read did not deliver its beat");
`endif

endmodule : bounded_stack_palindrome_check_core
`default_nettype wire
